### sv/wpe_pkg.sv
// ----------------------------------------------------------------------------
// Weighted percentile engine package
// Shared types, widths and codes for the percentile engine.
// ----------------------------------------------------------------------------
package wpe_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned WGT_W  = 40;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned TC_W   = 58;
  localparam int unsigned QUOT_W = 17;

  localparam logic [FRAC_W-1:0] Q16_ONE  = 17'd65536;
  localparam logic [FRAC_W-1:0] Q16_HALF = 17'd32768;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] METH_HAVG  = 3'd0;
  localparam logic [2:0] METH_WAVG  = 3'd1;
  localparam logic [2:0] METH_ROUND = 3'd2;
  localparam logic [2:0] METH_EMP   = 3'd3;
  localparam logic [2:0] METH_EMPAV = 3'd4;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [WGT_W-1:0] weight;
    logic [WGT_W-1:0] cumulative;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [TC_W-1:0]  dividend;
    logic [WGT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

### sv/wpe_store.sv
// ----------------------------------------------------------------------------
// Observation store
// One write port, one registered read port over the observation entries.
// ----------------------------------------------------------------------------
module wpe_store #(
  parameter int unsigned MaxEntries = wpe_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned AddrW      = $clog2(MaxEntries)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  wpe_pkg::entry_t     wr_entry_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output wpe_pkg::entry_t     rd_entry_o
);
  import wpe_pkg::*;

  entry_t mem_q [MaxEntries];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_entry_o = rd_q;

endmodule

### sv/wpe_divider.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider giving a Q.16 quotient saturated to 1.0, one bit a cycle.
// ----------------------------------------------------------------------------
module wpe_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpe_pkg::div_req_t req_i,
  output wpe_pkg::div_rsp_t rsp_o
);
  import wpe_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic              sat_q;
  logic [4:0]        step_q;
  logic [TC_W-1:0]   rem_q;
  logic [TC_W-1:0]   dsh_q;
  logic [QUOT_W-1:0] quot_q;
  logic [TC_W-1:0]   lim;
  logic              fits;

  assign lim  = {1'b0, req_i.divisor, 17'd0};
  assign fits = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.divisor == '0 || req_i.dividend >= lim) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          step_q <= 5'd16;
        end
      end else if (busy_q) begin
        step_q <= step_q - 5'd1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sat_q  <= (req_i.divisor == '0) || (req_i.dividend >= lim);
      rem_q  <= req_i.dividend;
      dsh_q  <= {2'd0, req_i.divisor, 16'd0};
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    if (sat_q || quot_q > Q16_ONE) begin
      rsp_o.quot = Q16_ONE;
    end else begin
      rsp_o.quot = quot_q;
    end
  end

endmodule

### sv/weighted_percentile_engine_top.sv
// ----------------------------------------------------------------------------
// Weighted percentile engine
// Sorted weighted observation list with percentile queries.
// ----------------------------------------------------------------------------
// Clear and append requests do not stall the input. The scan reads the
// store once per entry. The DRAIN, RD1, RD2 and RD3 states finish the scan
// and read the neighbour entries. Then come the bit-serial divider and the
// shared blend multiplier. A saturated quotient ends the division at once,
// and a method that picks an entry instead of blending skips the
// multiplier. A stalled result holds the engine for as long as the stall
// lasts. The input stalls for the whole of a query. An empty list or a
// method code above 4 answers with status 1.
module weighted_percentile_engine_top #(
  parameter int unsigned MaxEntries = wpe_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_method_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic signed [31:0]  obs_value_i,
  input  logic [39:0]         obs_weight_i,
  input  logic [39:0]         obs_cumulative_i,
  input  logic [16:0]         fraction_i,
  input  logic [39:0]         total_weight_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  percentile_value_o,
  output logic                status_o
);
  import wpe_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxEntries);
  localparam int unsigned CntW  = $clog2(MaxEntries + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TC1   = 4'd1;
  localparam logic [3:0] S_TC2   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_RD1   = 4'd5;
  localparam logic [3:0] S_RD2   = 4'd6;
  localparam logic [3:0] S_RD3   = 4'd7;
  localparam logic [3:0] S_DIVGO = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_SEL   = 4'd10;
  localparam logic [3:0] S_MULA  = 4'd11;
  localparam logic [3:0] S_MULB  = 4'd12;
  localparam logic [3:0] S_ROUND = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]        state_q, state_d;
  logic [2:0]        method_q;
  logic [CntW-1:0]   count_q;
  logic [AddrW-1:0]  rd_idx_q;
  logic              chk_vld_q;
  logic [AddrW-1:0]  chk_idx_q;
  logic              k1_found_q, k2_found_q;
  logic [AddrW-1:0]  k1_q, k2_q;
  logic              out_valid_q;

  logic [FRAC_W-1:0] p_q;
  logic [WGT_W-1:0]  w_q;
  logic [56:0]       tc1_q;
  logic [TC_W-1:0]   tc2_q;
  logic [WGT_W-1:0]  cc1_q, cc2_q;
  logic [VAL_W-1:0]  va1_q, va2_q, val0_q;
  logic [VAL_W-1:0]  b1_q, b2_q;
  logic [WGT_W-1:0]  wt1_q, wt2_q;
  logic [TC_W-1:0]   g1s_q, g2s_q;
  logic              top2_q;
  logic signed [31:0] bl_a_q, bl_b_q;
  logic [FRAC_W-1:0] bl_f_q;
  logic signed [49:0] prod_q, acc_q;
  logic [VAL_W-1:0]  res_val_q, out_val_q;
  logic              res_st_q, out_st_q;

  logic              in_acc, out_free, last_rd;
  logic              wr_en;
  entry_t            wr_entry, rd_entry;
  logic [AddrW-1:0]  rd_addr, nx1, nx2, last_addr;
  logic [CntW-1:0]   k1p, k2p;
  logic [TC_W-1:0]   cmp_c;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              sel_blend;
  logic [VAL_W-1:0]  sel_res, sel_a, sel_b;
  logic [FRAC_W-1:0] sel_f;
  logic [VAL_W-1:0]  a1, a2, vk1c, vk2c;
  logic              heavy1, heavy2;
  logic signed [17:0] mul_x;
  logic signed [31:0] mul_y;
  logic signed [49:0] mul_p;
  logic signed [49:0] rnd_sum, rnd_sh;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign last_addr = AddrW'(count_q - CntW'(1));
  assign last_rd   = (rd_idx_q == last_addr);
  assign k1p       = CntW'(k1_q) + CntW'(1);
  assign k2p       = CntW'(k2_q) + CntW'(1);
  assign nx1       = !k1_found_q ? '0 : (k1p >= count_q ? last_addr : k1p[AddrW-1:0]);
  assign nx2       = !k2_found_q ? '0 : (k2p >= count_q ? last_addr : k2p[AddrW-1:0]);

  assign wr_en = in_acc && opcode_i == OP_APPEND && count_q < CntW'(MaxEntries);
  assign wr_entry.value      = obs_value_i;
  assign wr_entry.weight     = obs_weight_i;
  assign wr_entry.cumulative = obs_cumulative_i;

  always_comb begin
    unique case (state_q)
      S_RD1:   rd_addr = nx1;
      S_RD2:   rd_addr = nx2;
      default: rd_addr = rd_idx_q;
    endcase
  end

  wpe_store #(
    .MaxEntries(MaxEntries),
    .AddrW     (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_entry_i(wr_entry),
    .rd_addr_i (rd_addr),
    .rd_entry_o(rd_entry)
  );

  always_comb begin
    div_req.start = (state_q == S_DIVGO);
    if (method_q == METH_HAVG) begin
      div_req.dividend = g2s_q;
      div_req.divisor  = wt2_q;
    end else begin
      div_req.dividend = g1s_q;
      div_req.divisor  = wt1_q;
    end
  end

  wpe_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && opcode_i == OP_QUERY) begin
          if (count_q == '0 || method_q > METH_EMPAV) begin
            state_d = S_DONE;
          end else begin
            state_d = S_TC1;
          end
        end
      end
      S_TC1:   state_d = S_TC2;
      S_TC2:   state_d = S_SCAN;
      S_SCAN:  state_d = last_rd ? S_DRAIN : S_SCAN;
      S_DRAIN: state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_RD3;
      S_RD3:   state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIV;
      S_DIV:   state_d = div_rsp.done ? S_SEL : S_DIV;
      S_SEL:   state_d = sel_blend ? S_MULA : S_DONE;
      S_MULA:  state_d = S_MULB;
      S_MULB:  state_d = S_ROUND;
      S_ROUND: state_d = S_DONE;
      S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      method_q    <= METH_HAVG;
      count_q     <= '0;
      rd_idx_q    <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      k1_found_q  <= 1'b0;
      k2_found_q  <= 1'b0;
      k1_q        <= '0;
      k2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        method_q <= cfg_method_i;
      end
      if (in_acc && opcode_i == OP_CLEAR) begin
        count_q <= '0;
      end else if (wr_en) begin
        count_q <= count_q + CntW'(1);
      end
      chk_vld_q <= (state_q == S_SCAN);
      chk_idx_q <= rd_idx_q;
      if (state_q == S_TC2) begin
        rd_idx_q   <= '0;
        k1_found_q <= 1'b0;
        k2_found_q <= 1'b0;
      end else if (state_q == S_SCAN && !last_rd) begin
        rd_idx_q <= rd_idx_q + AddrW'(1);
      end
      if (chk_vld_q) begin
        if (cmp_c <= {1'b0, tc1_q}) begin
          k1_found_q <= 1'b1;
          k1_q       <= chk_idx_q;
        end
        if (cmp_c <= tc2_q) begin
          k2_found_q <= 1'b1;
          k2_q       <= chk_idx_q;
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmp_c = {2'd0, rd_entry.cumulative, 16'd0};

  // Outcome by method
  assign heavy1 = |wt1_q[WGT_W-1:16];
  assign heavy2 = |wt2_q[WGT_W-1:16];
  assign a1     = k1_found_q ? va1_q : '0;
  assign a2     = k2_found_q ? va2_q : '0;
  assign vk1c   = k1_found_q ? va1_q : val0_q;
  assign vk2c   = k2_found_q ? va2_q : val0_q;

  always_comb begin
    sel_blend = 1'b0;
    sel_res   = b1_q;
    sel_a     = a1;
    sel_b     = b1_q;
    sel_f     = div_rsp.quot;
    unique case (method_q)
      METH_HAVG: begin
        sel_a = a2;
        sel_b = b2_q;
        if (top2_q) begin
          sel_res = va2_q;
        end else if (|g2s_q[TC_W-1:32]) begin
          sel_res = b2_q;
        end else if (g2s_q == '0) begin
          sel_res = vk2c;
        end else begin
          sel_blend = 1'b1;
          sel_f     = heavy2 ? {1'b0, g2s_q[31:16]} : div_rsp.quot;
        end
      end
      METH_WAVG: begin
        if (|g1s_q[TC_W-1:32]) begin
          sel_res = b1_q;
        end else begin
          sel_blend = 1'b1;
          sel_f     = heavy1 ? {1'b0, g1s_q[31:16]} : div_rsp.quot;
        end
      end
      METH_ROUND: begin
        if (heavy1 ? !(|g1s_q[TC_W-1:31]) : (div_rsp.quot < Q16_HALF)) begin
          sel_res = a1;
        end else begin
          sel_res = b1_q;
        end
      end
      METH_EMP: begin
        sel_res = (g1s_q != '0) ? b1_q : vk1c;
      end
      default: begin
        if (g1s_q != '0) begin
          sel_res = b1_q;
        end else begin
          sel_blend = 1'b1;
          sel_a     = vk1c;
          sel_f     = Q16_HALF;
        end
      end
    endcase
  end

  // Shared blend multiplier: (1-f)*a, then f*b
  assign mul_x = (state_q == S_MULA) ? signed'({1'b0, Q16_ONE - bl_f_q})
                                     : signed'({1'b0, bl_f_q});
  assign mul_y = (state_q == S_MULA) ? bl_a_q : bl_b_q;
  assign mul_p = mul_x * mul_y;

  assign rnd_sum = acc_q + 50'sd32768;
  assign rnd_sh  = rnd_sum >>> 16;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        p_q       <= (fraction_i > Q16_ONE) ? Q16_ONE : fraction_i;
        w_q       <= total_weight_i;
        res_val_q <= '0;
        res_st_q  <= 1'b1;
      end
      S_TC1: tc1_q <= 57'({17'd0, w_q} * {40'd0, p_q});
      S_TC2: tc2_q <= {1'b0, tc1_q} + {25'd0, p_q, 16'd0};
      S_RD1: begin
        top2_q <= k2_found_q && (k2p >= count_q);
      end
      S_RD2: begin
        b1_q  <= rd_entry.value;
        wt1_q <= rd_entry.weight;
        g1s_q <= {1'b0, tc1_q} - (k1_found_q ? {2'd0, cc1_q, 16'd0} : '0);
      end
      S_RD3: begin
        b2_q  <= rd_entry.value;
        wt2_q <= rd_entry.weight;
        g2s_q <= tc2_q - (k2_found_q ? {2'd0, cc2_q, 16'd0} : '0);
      end
      S_SEL: begin
        res_val_q <= sel_res;
        res_st_q  <= 1'b0;
        bl_a_q    <= sel_a;
        bl_b_q    <= sel_b;
        bl_f_q    <= sel_f;
      end
      S_MULA: prod_q <= mul_p;
      S_MULB: acc_q  <= prod_q + mul_p;
      S_ROUND: begin
        if (rnd_sh > 50'sd2147483647) begin
          res_val_q <= 32'h7fff_ffff;
        end else if (rnd_sh < -50'sd2147483648) begin
          res_val_q <= 32'h8000_0000;
        end else begin
          res_val_q <= rnd_sh[31:0];
        end
      end
      default: ;
    endcase
    if (chk_vld_q) begin
      if (chk_idx_q == '0) begin
        val0_q <= rd_entry.value;
      end
      if (cmp_c <= {1'b0, tc1_q}) begin
        cc1_q <= rd_entry.cumulative;
        va1_q <= rd_entry.value;
      end
      if (cmp_c <= tc2_q) begin
        cc2_q <= rd_entry.cumulative;
        va2_q <= rd_entry.value;
      end
    end
    if (state_q == S_DONE && out_free) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign percentile_value_o = out_val_q;
  assign status_o           = out_st_q;

endmodule

### sv/wpe_checker.sv
// ----------------------------------------------------------------------------
// Weighted percentile engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module wpe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         opcode_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] percentile_value_o,
  input logic               status_o
);
  import wpe_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(percentile_value_o)
      && $stable(status_o))
    else $error("stalled result changed");

  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> percentile_value_o == '0)
    else $error("missing result carries a value");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == OP_QUERY |=> in_stall_o)
    else $error("query did not hold the input");

  a_list_op_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i != OP_QUERY |=> !in_stall_o)
    else $error("list request stalled the input");

endmodule

bind weighted_percentile_engine_top wpe_checker u_wpe_checker (.*);
